@@ rtl/ugsq_pkg.sv @@
// Shared types, codes and constants for the undirected graph store.
package ugsq_pkg;

  localparam int unsigned MAX_VERTICES = 256;
  localparam int unsigned VIDX_W       = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = 9;
  localparam int unsigned DEG_W        = 8;
  localparam int unsigned EDGE_W       = 15;
  localparam int unsigned VTX_W        = 12;

  localparam logic [63:0] GOLDEN    = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2    = 64'h94d049bb133111eb;
  localparam logic [63:0] EDGE_SALT = 64'h00000100000001b3;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_CHK,
    S_LD_WRU,
    S_LD_WRV,
    S_Q_ANS,
    S_B_ADDR,
    S_B_DATA,
    S_B_ENCA,
    S_B_ENCB,
    S_B_MIX,
    S_B_MIXW,
    S_B_MOD,
    S_B_MODW
  } state_t;

endpackage

@@ rtl/ugsq_ram.sv @@
// Generic single-port RAM with registered read.
module ugsq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/ugsq_mix.sv @@
// Iterative 64-bit finalizer mix on one shared 32x32 multiplier.
module ugsq_mix
  import ugsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x_in,
  output logic        done,
  output logic [63:0] x_out
);

  logic [63:0] x;
  logic [63:0] acc;
  logic [3:0]  step;
  logic        active;
  logic [63:0] c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  always_comb begin
    c     = (step < 4'd4) ? MIX_C1 : MIX_C2;
    mul_a = (step == 4'd3 || step == 4'd7) ? x[63:32] : x[31:0];
    mul_b = (step == 4'd2 || step == 4'd6) ? c[63:32] : c[31:0];
    prod  = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x      <= x_in ^ (x_in >> 30);
        step   <= 4'd1;
        active <= 1'b1;
      end else if (active) begin
        step <= step + 4'd1;
        case (step)
          4'd1, 4'd5: acc <= prod;
          4'd2, 4'd6: acc <= acc + {prod[31:0], 32'd0};
          4'd3, 4'd7: x   <= acc + {prod[31:0], 32'd0};
          4'd4:       x   <= x ^ (x >> 27);
          4'd8: begin
            x      <= x ^ (x >> 31);
            active <= 1'b0;
            done   <= 1'b1;
          end
          default: active <= 1'b0;
        endcase
      end
    end
  end

  assign x_out = x;

endmodule

@@ rtl/ugsq_mod.sv @@
// Bit-serial remainder of a 64-bit value by the vertex count.
module ugsq_mod
  import ugsq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [CNT_W-1:0] rem
);

  logic [63:0]    q;
  logic [6:0]     cnt;
  logic           active;
  logic [CNT_W:0] t;

  assign t = {rem, q[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q      <= dividend;
        rem    <= '0;
        cnt    <= '0;
        active <= 1'b1;
      end else if (active) begin
        q <= q << 1;
        if (t >= {1'b0, divisor}) begin
          rem <= CNT_W'(t - {1'b0, divisor});
        end else begin
          rem <= t[CNT_W-1:0];
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/undirected_graph_store_query.sv @@
// Graph store: adjacency rows in RAM, per-vertex degrees, build summary and queries.
// Commands: clear, self-loop and out-of-range loads never leave idle; duplicate loads end
//   after the row check; queries answer on acceptance if an endpoint is out of range or empty.
// Build: a scan of every vertex row, the encode states, up to 6 mixes on the shared
//   multiplier, then the serial remainder.
// Results appear on the ports for one cycle with result_valid; the receiver cannot stall.
// Synchronous reset clears vertex count, row valid bits and the edge count at once.
module undirected_graph_store_query
  import ugsq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [VTX_W-1:0]  first_vertex,
  input  logic [VTX_W-1:0]  second_vertex,
  input  logic              cfg_write,
  input  logic [CNT_W-1:0]  cfg_data,
  output logic              result_valid,
  output logic              answer_kind,
  output logic [1:0]        status,
  output logic [EDGE_W-1:0] distinct_edges,
  output logic [DEG_W-1:0]  least_degree,
  output logic [DEG_W-1:0]  greatest_degree,
  output logic [DEG_W-1:0]  chosen_vertex,
  output logic              edge_found,
  output logic [DEG_W-1:0]  vertex_degree
);

  state_t state, state_next;

  logic [CNT_W-1:0]        vertex_total;
  logic [CNT_W-1:0]        n;
  logic [MAX_VERTICES-1:0] row_valid;
  logic                    rd_valid;
  logic [EDGE_W-1:0]       edge_total;

  // Latched command operands and working rows
  logic [VIDX_W-1:0]       u;
  logic [VIDX_W-1:0]       v;
  logic [MAX_VERTICES-1:0] rowu;
  logic [MAX_VERTICES-1:0] rowv;
  logic [DEG_W-1:0]        degu;
  logic [DEG_W-1:0]        degv;

  // Build scan state
  logic [VIDX_W-1:0]       idx;
  logic [DEG_W-1:0]        least;
  logic [DEG_W-1:0]        greatest;
  logic                    any;
  logic [MAX_VERTICES-1:0] arow;
  logic [MAX_VERTICES-1:0] brow;
  logic [VIDX_W-1:0]       a_nb;
  logic [VIDX_W-1:0]       b_nb;
  logic [63:0]             h;
  logic [2:0]              k;

  // RAM ports
  logic                    ram_we;
  logic [VIDX_W-1:0]       ram_addr;
  logic [MAX_VERTICES-1:0] row_wdata;
  logic [DEG_W-1:0]        deg_wdata;
  logic [MAX_VERTICES-1:0] row_q;
  logic [DEG_W-1:0]        deg_q;
  logic [MAX_VERTICES-1:0] row_rd;
  logic [DEG_W-1:0]        deg_rd;

  logic                    mix_start;
  logic                    mix_done;
  logic [63:0]             mix_in;
  logic [63:0]             mix_out;
  logic                    mod_start;
  logic                    mod_done;
  logic [CNT_W-1:0]        mod_rem;

  logic                    accept;
  logic                    u_in;
  logic                    v_in;
  logic                    ld_ok;
  logic                    last_row;
  logic                    mix_last;

  function automatic logic [VIDX_W-1:0] lowest_set(input logic [MAX_VERTICES-1:0] r);
    logic [VIDX_W-1:0] p;
    p = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (r[i]) p = VIDX_W'(i);
    end
    return p;
  endfunction

  function automatic logic [VIDX_W-1:0] highest_set(input logic [MAX_VERTICES-1:0] r);
    logic [VIDX_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (r[i]) p = VIDX_W'(i);
    end
    return p;
  endfunction

  assign n = (vertex_total < CNT_W'(MAX_VERTICES)) ? vertex_total : CNT_W'(MAX_VERTICES);
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign u_in     = {{(VTX_W-CNT_W){1'b0}}, n} > first_vertex;
  assign v_in     = {{(VTX_W-CNT_W){1'b0}}, n} > second_vertex;
  assign ld_ok    = u_in && v_in && (first_vertex != second_vertex);
  assign row_rd   = rd_valid ? row_q : '0;
  assign deg_rd   = rd_valid ? deg_q : '0;
  assign last_row = ({1'b0, idx} == (n - CNT_W'(1)));
  assign mix_last = (k == 3'd5) || (k == 3'd3 && !any);

  ugsq_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_rows (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(row_wdata), .rdata(row_q)
  );

  ugsq_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_degs (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(deg_wdata), .rdata(deg_q)
  );

  ugsq_mix u_mix (
    .clk(clk), .rst(rst), .start(mix_start), .x_in(mix_in), .done(mix_done), .x_out(mix_out)
  );

  ugsq_mod u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(h), .divisor(n),
    .done(mod_done), .rem(mod_rem)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(command))
            CMD_LOAD:  if (ld_ok) state_next = S_LD_CHK;
            CMD_BUILD: if (n != '0) state_next = S_B_ADDR;
            CMD_QUERY: if (n != '0 && u_in && v_in) state_next = S_Q_ANS;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_LD_CHK: state_next = row_rd[v] ? S_IDLE : S_LD_WRU;
      S_LD_WRU: state_next = S_LD_WRV;
      S_LD_WRV: state_next = S_IDLE;
      S_Q_ANS:  state_next = S_IDLE;
      S_B_ADDR: state_next = S_B_DATA;
      S_B_DATA: state_next = last_row ? S_B_ENCA : S_B_ADDR;
      S_B_ENCA: state_next = S_B_ENCB;
      S_B_ENCB: state_next = S_B_MIX;
      S_B_MIX:  state_next = S_B_MIXW;
      S_B_MIXW: begin
        if (mix_done) state_next = mix_last ? S_B_MOD : S_B_MIX;
      end
      S_B_MOD:  state_next = S_B_MODW;
      S_B_MODW: if (mod_done) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // RAM and unit control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx;
    row_wdata = rowu | (MAX_VERTICES'(1) << v);
    deg_wdata = degu + DEG_W'(1);
    mix_start = (state == S_B_MIX);
    mod_start = (state == S_B_MOD);
    case (k)
      3'd0:    mix_in = 64'(n);
      3'd1:    mix_in = 64'(edge_total) + EDGE_SALT;
      3'd2:    mix_in = 64'(greatest) << 1;
      3'd3:    mix_in = 64'(least) << 7;
      3'd4:    mix_in = 64'(a_nb) << 17;
      default: mix_in = 64'(b_nb) << 29;
    endcase
    case (state)
      S_IDLE:   ram_addr = first_vertex[VIDX_W-1:0];
      S_LD_CHK: ram_addr = v;
      S_LD_WRU: begin
        ram_addr = u;
        ram_we   = 1'b1;
      end
      S_LD_WRV: begin
        ram_addr  = v;
        ram_we    = 1'b1;
        row_wdata = rowv | (MAX_VERTICES'(1) << u);
        deg_wdata = degv + DEG_W'(1);
      end
      default: ram_addr = idx;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_total <= '0;
      row_valid    <= '0;
      edge_total   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_write) begin
        vertex_total <= cfg_data;
        row_valid    <= '0;
        edge_total   <= '0;
      end
      if (accept && cmd_t'(command) == CMD_CLEAR) begin
        row_valid  <= '0;
        edge_total <= '0;
      end
      if (ram_we) row_valid[ram_addr] <= 1'b1;
      if (state == S_LD_WRV) edge_total <= edge_total + EDGE_W'(1);
      // Immediate answers: empty graph or endpoint out of range
      if (accept && cmd_t'(command) == CMD_QUERY && !(n != '0 && u_in && v_in)) begin
        result_valid <= 1'b1;
      end
      if (accept && cmd_t'(command) == CMD_BUILD && n == '0) result_valid <= 1'b1;
      if (state == S_Q_ANS) result_valid <= 1'b1;
      if (state == S_B_MODW && mod_done) result_valid <= 1'b1;
    end
  end

  // Datapath and result fields
  always_ff @(posedge clk) begin
    rd_valid <= row_valid[ram_addr];
    if (accept) begin
      u <= first_vertex[VIDX_W-1:0];
      v <= second_vertex[VIDX_W-1:0];
      answer_kind     <= (cmd_t'(command) == CMD_QUERY) ? KIND_QUERY : KIND_BUILD;
      status          <= (n == '0) ? ST_EMPTY : ST_RANGE;
      distinct_edges  <= '0;
      least_degree    <= '0;
      greatest_degree <= '0;
      chosen_vertex   <= '0;
      edge_found      <= 1'b0;
      vertex_degree   <= '0;
      idx      <= '0;
      least    <= '1;
      greatest <= '0;
      any      <= 1'b0;
      h        <= GOLDEN;
      k        <= '0;
    end
    case (state)
      S_LD_CHK: begin
        rowu <= row_rd;
        degu <= deg_rd;
      end
      S_LD_WRU: begin
        rowv <= row_rd;
        degv <= deg_rd;
      end
      S_Q_ANS: begin
        status        <= ST_OK;
        edge_found    <= (u != v) && row_rd[v];
        vertex_degree <= deg_rd;
      end
      S_B_DATA: begin
        if (deg_rd < least) least <= deg_rd;
        if (deg_rd > greatest) greatest <= deg_rd;
        if (deg_rd != '0) begin
          if (!any) arow <= row_rd;
          any  <= 1'b1;
          brow <= row_rd;
        end
        idx <= idx + VIDX_W'(1);
      end
      S_B_ENCA: a_nb <= lowest_set(arow);
      S_B_ENCB: b_nb <= highest_set(brow);
      S_B_MIXW: begin
        if (mix_done) begin
          h <= h ^ mix_out;
          k <= k + 3'd1;
        end
      end
      S_B_MODW: begin
        if (mod_done) begin
          status          <= ST_OK;
          distinct_edges  <= edge_total;
          least_degree    <= least;
          greatest_degree <= greatest;
          chosen_vertex   <= mod_rem[DEG_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

@@ tb/tb_undirected_graph_store_query.sv @@
// Self-checking testbench for the undirected graph store: directed table, then random beats.
`timescale 1ns / 1ps

module tb_undirected_graph_store_query;
  import ugsq_pkg::*;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        command;
  logic [VTX_W-1:0]  first_vertex;
  logic [VTX_W-1:0]  second_vertex;
  logic              cfg_write;
  logic [CNT_W-1:0]  cfg_data;
  logic              result_valid;
  logic              answer_kind;
  logic [1:0]        status;
  logic [EDGE_W-1:0] distinct_edges;
  logic [DEG_W-1:0]  least_degree;
  logic [DEG_W-1:0]  greatest_degree;
  logic [DEG_W-1:0]  chosen_vertex;
  logic              edge_found;
  logic [DEG_W-1:0]  vertex_degree;

  // One result beat, field by field.
  typedef struct packed {
    logic              kind;
    logic [1:0]        stat;
    logic [EDGE_W-1:0] edges;
    logic [DEG_W-1:0]  least;
    logic [DEG_W-1:0]  most;
    logic [DEG_W-1:0]  pick;
    logic              found;
    logic [DEG_W-1:0]  deg;
  } answer_t;

  // One row of the directed table; has_gold marks rows with a typed-in answer.
  typedef struct {
    cmd_t             cmd;
    logic [VTX_W-1:0] u;
    logic [VTX_W-1:0] v;
    bit               has_gold;
    answer_t          gold;
  } stim_row_t;

  undirected_graph_store_query i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .first_vertex(first_vertex), .second_vertex(second_vertex),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .result_valid(result_valid), .answer_kind(answer_kind), .status(status),
    .distinct_edges(distinct_edges), .least_degree(least_degree),
    .greatest_degree(greatest_degree), .chosen_vertex(chosen_vertex),
    .edge_found(edge_found), .vertex_degree(vertex_degree)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Predictor state: its own copy of the graph and of the vertex count.
  bit          adj_mirror [MAX_VERTICES][MAX_VERTICES];
  int unsigned deg_mirror [MAX_VERTICES];
  int unsigned vcount;
  answer_t     pending_answers[$];
  int          errors;
  bit          quiet_phase;   // disables random idling for a stretch

  function automatic void enqueue_answer(answer_t a);
    pending_answers.insert(pending_answers.size(), a);
  endfunction

  function automatic void wipe_graph();
    foreach (adj_mirror[i, j]) adj_mirror[i][j] = 1'b0;
    foreach (deg_mirror[i]) deg_mirror[i] = 0;
  endfunction

  function automatic logic [63:0] mix64(logic [63:0] x);
    x = x ^ (x >> 30);
    x = x * MIX_C1;
    x = x ^ (x >> 27);
    x = x * MIX_C2;
    x = x ^ (x >> 31);
    return x;
  endfunction

  function automatic int unsigned live_count();
    return (vcount < MAX_VERTICES) ? vcount : MAX_VERTICES;
  endfunction

  // Summary over the whole graph, as a build beat should report it.
  function automatic answer_t summarize_graph();
    answer_t     r;
    int unsigned n, least, most, edges, d;
    bit          any;
    logic [63:0] a, b, h;
    r = '0;
    r.kind = KIND_BUILD;
    n = live_count();
    if (n == 0) begin
      r.stat = ST_EMPTY;
      return r;
    end
    least = 32'hFFFF_FFFF;
    most = 0;
    edges = 0;
    any = 0;
    a = 0;
    b = 0;
    for (int u = 0; u < n; u++) begin
      d = 0;
      for (int v = 0; v < n; v++) begin
        if (adj_mirror[u][v]) begin
          d++;
          if (v > u) edges++;
          if (!any) begin
            a = v;
            any = 1;
          end
          b = v;
        end
      end
      if (d < least) least = d;
      if (d > most) most = d;
    end
    h = GOLDEN;
    h ^= mix64(64'(n));
    h ^= mix64(64'(edges) + EDGE_SALT);
    h ^= mix64(64'(most) << 1);
    h ^= mix64(64'(least) << 7);
    if (any) begin
      h ^= mix64(a << 17);
      h ^= mix64(b << 29);
    end
    r.stat = ST_OK;
    r.edges = edges[EDGE_W-1:0];
    r.least = least[DEG_W-1:0];
    r.most = most[DEG_W-1:0];
    r.pick = 8'(h % 64'(n));
    return r;
  endfunction

  // Apply one command to the mirror; queue the expected beat if it yields one.
  function automatic void predict_command(cmd_t cmd, int unsigned u, int unsigned v);
    answer_t     r;
    int unsigned n;
    n = live_count();
    case (cmd)
      CMD_CLEAR: wipe_graph();
      CMD_LOAD: begin
        if (u != v && u < n && v < n && !adj_mirror[u][v]) begin
          adj_mirror[u][v] = 1'b1;
          adj_mirror[v][u] = 1'b1;
          deg_mirror[u]++;
          deg_mirror[v]++;
        end
      end
      CMD_BUILD: enqueue_answer(summarize_graph());
      default: begin
        r = '0;
        r.kind = KIND_QUERY;
        if (n == 0) r.stat = ST_EMPTY;
        else if (u >= n || v >= n) r.stat = ST_RANGE;
        else begin
          r.stat = ST_OK;
          r.found = (u != v) && adj_mirror[u][v];
          r.deg = deg_mirror[u][DEG_W-1:0];
        end
        enqueue_answer(r);
      end
    endcase
  endfunction

  // Check every result beat against the oldest expectation.
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && result_valid) begin
      got = '{answer_kind, status, distinct_edges, least_degree, greatest_degree,
              chosen_vertex, edge_found, vertex_degree};
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: answer_kind exp %0d got %0d", $time, want.kind, got.kind);
          errors++;
        end
        if (got.stat !== want.stat) begin
          $display("%0t: status exp %0d got %0d", $time, want.stat, got.stat);
          errors++;
        end
        if (got.edges !== want.edges) begin
          $display("%0t: distinct_edges exp %0d got %0d", $time, want.edges, got.edges);
          errors++;
        end
        if (got.least !== want.least) begin
          $display("%0t: least_degree exp %0d got %0d", $time, want.least, got.least);
          errors++;
        end
        if (got.most !== want.most) begin
          $display("%0t: greatest_degree exp %0d got %0d", $time, want.most, got.most);
          errors++;
        end
        if (got.pick !== want.pick) begin
          $display("%0t: chosen_vertex exp %0d got %0d", $time, want.pick, got.pick);
          errors++;
        end
        if (got.found !== want.found) begin
          $display("%0t: edge_found exp %0d got %0d", $time, want.found, got.found);
          errors++;
        end
        if (got.deg !== want.deg) begin
          $display("%0t: vertex_degree exp %0d got %0d", $time, want.deg, got.deg);
          errors++;
        end
      end
    end
  end

  // Send one command beat: optional idle gap, then hold start until busy is low.
  // Start stays high after the accepting edge; the next beat or a drain drops it.
  task automatic send_command(cmd_t cmd, logic [VTX_W-1:0] u, logic [VTX_W-1:0] v);
    while (!quiet_phase && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    first_vertex <= u;
    second_vertex <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Beat taken at this edge; mirror it now.
    predict_command(cmd, u, v);
  endtask

  // Drop start, wait for all answers, then let a trailing load or clear finish too.
  task automatic drain_answers();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the vertex count; only called while the block is idle.
  task automatic set_vertex_total(logic [CNT_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    vcount = value;
    wipe_graph();
    @(posedge clk);
  endtask

  // Pick an endpoint: mostly in range, sometimes just out, sometimes anywhere.
  function automatic logic [VTX_W-1:0] pick_vertex();
    int unsigned n, r;
    n = live_count();
    r = $urandom_range(99);
    if (n == 0 || r < 4) return VTX_W'($urandom());
    if (r < 8) return VTX_W'(n + $urandom_range(3));
    return VTX_W'($urandom_range(n - 1));
  endfunction

  // Random phase: mostly loads, with builds, queries and the odd clear.
  task automatic random_phase(int beats);
    int          r;
    cmd_t        cmd;
    logic [VTX_W-1:0] u, v;
    for (int i = 0; i < beats; i++) begin
      r = $urandom_range(99);
      if (r < 55) cmd = CMD_LOAD;
      else if (r < 63) cmd = CMD_BUILD;
      else if (r < 97) cmd = CMD_QUERY;
      else cmd = CMD_CLEAR;
      u = pick_vertex();
      v = ($urandom_range(9) == 0) ? u : pick_vertex();
      send_command(cmd, u, v);
    end
  endtask

  stim_row_t directed[$];

  function automatic stim_row_t row(cmd_t c, int u, int v, bit g = 0, answer_t a = '0);
    stim_row_t s;
    s.cmd = c;
    s.u = VTX_W'(u);
    s.v = VTX_W'(v);
    s.has_gold = g;
    s.gold = a;
    return s;
  endfunction

  function automatic void add_row(cmd_t c, int u, int v, bit g = 0, answer_t a = '0);
    directed.insert(directed.size(), row(c, u, v, g, a));
  endfunction

  initial begin
    answer_t empty_q, empty_b, range_q;
    errors = 0;
    quiet_phase = 0;
    vcount = 0;
    wipe_graph();
    rst = 1'b1;
    start = 1'b0;
    command = CMD_CLEAR;
    first_vertex = '0;
    second_vertex = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    empty_b = '0;
    empty_b.kind = KIND_BUILD;
    empty_b.stat = ST_EMPTY;
    empty_q = '0;
    empty_q.kind = KIND_QUERY;
    empty_q.stat = ST_EMPTY;
    range_q = '0;
    range_q.kind = KIND_QUERY;
    range_q.stat = ST_RANGE;

    // Directed part 1: no vertices after reset.
    add_row(CMD_BUILD, 0, 0, 1, empty_b);
    add_row(CMD_QUERY, 4095, 4095, 1, empty_q);
    add_row(CMD_LOAD, 0, 1);
    add_row(CMD_BUILD, 0, 0, 1, empty_b);
    foreach (directed[i]) begin
      if (directed[i].has_gold) enqueue_answer(directed[i].gold);
      send_command(directed[i].cmd, directed[i].u, directed[i].v);
      if (directed[i].has_gold) void'(pending_answers.pop_back());
    end
    drain_answers();

    // Directed part 2: full 256-vertex graph, extremes and special cases.
    set_vertex_total(9'd256);
    directed.delete();
    add_row(CMD_LOAD, 0, 255);
    add_row(CMD_LOAD, 255, 0);       // reversed duplicate
    add_row(CMD_LOAD, 7, 7);         // self loop
    add_row(CMD_LOAD, 256, 3);       // out of range
    add_row(CMD_LOAD, 3, 4095);
    add_row(CMD_LOAD, 0, 1);
    add_row(CMD_QUERY, 0, 255);
    add_row(CMD_QUERY, 255, 0);
    add_row(CMD_QUERY, 0, 0);        // equal endpoints
    add_row(CMD_QUERY, 4095, 0, 1, range_q);
    add_row(CMD_QUERY, 0, 2730, 1, range_q);
    add_row(CMD_QUERY, 1365, 3);
    add_row(CMD_BUILD, 0, 0);
    add_row(CMD_CLEAR, 4095, 4095);
    add_row(CMD_BUILD, 0, 0);
    add_row(CMD_QUERY, 0, 255);
    foreach (directed[i]) begin
      // A typed-in answer must agree with the predictor as well.
      send_command(directed[i].cmd, directed[i].u, directed[i].v);
      if (directed[i].has_gold && pending_answers[$] !== directed[i].gold) begin
        $display("%0t: table row %0d disagrees with predictor", $time, i);
        errors++;
      end
    end
    drain_answers();

    // Random phases across several vertex counts, extremes included.
    set_vertex_total(9'd2);
    random_phase(60);
    drain_answers();
    set_vertex_total(9'd1);
    random_phase(30);
    drain_answers();
    set_vertex_total(9'd511);
    random_phase(200);
    // Hold off until every answer is in, then run a stretch with no idling.
    drain_answers();
    quiet_phase = 1;
    random_phase(80);
    quiet_phase = 0;
    drain_answers();
    set_vertex_total(9'd5);
    random_phase(150);
    drain_answers();
    set_vertex_total(9'(9'd6 + $urandom_range(120)));
    random_phase(200);
    drain_answers();
    set_vertex_total(9'd0);
    random_phase(20);

    drain_answers();
    repeat (600) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the time any build of 256 vertices takes.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ugsq_pkg.sv
rtl/ugsq_ram.sv
rtl/ugsq_mix.sv
rtl/ugsq_mod.sv
rtl/undirected_graph_store_query.sv
tb/tb_undirected_graph_store_query.sv
